### src/apg_pkg.sv
`default_nettype none

package apg_pkg;

   // Milliseconds that pass with each tick
   localparam int unsigned MS_PER_TICK = 10;
   localparam int unsigned MS_PER_SECOND = 1000;

   localparam int unsigned VALUE_W = 24;
   localparam int unsigned COUNT_W = 25;
   localparam int unsigned MS_W = 10;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [VALUE_W-1:0] REPEAT_ON_RESET = VALUE_W'(2000);
   localparam logic [VALUE_W-1:0] REPEAT_OFF_RESET = VALUE_W'(1000);

   // Request codes
   typedef enum logic [2:0] {
      CMD_TICK = 3'd0,
      CMD_OFF = 3'd1,
      CMD_ON = 3'd2,
      CMD_REPEAT = 3'd3,
      CMD_PULSE = 3'd4,
      CMD_PULSE2 = 3'd5
   } apg_cmd_type;

   // Pattern currently driving the output
   typedef enum logic [2:0] {
      MODE_OFF = 3'd0,
      MODE_ON = 3'd1,
      MODE_REPEAT = 3'd2,
      MODE_PULSE = 3'd3,
      MODE_PULSE2 = 3'd4
   } apg_mode_type;

   typedef enum logic [1:0] {
      PHASE_ON = 2'd0,
      PHASE_OFF = 2'd1,
      PHASE_START = 2'd2
   } apg_phase_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [VALUE_W-1:0] first_value;
      logic [VALUE_W-1:0] second_value;
   } apg_req_type;

   typedef struct packed {
      logic alarm_level;
      logic command_ok;
   } apg_rsp_type;

endpackage

`default_nettype wire

### src/apg_req_if.sv
`default_nettype none

interface apg_req_if
   import apg_pkg::*;
();
   logic valid;
   logic ready;
   logic [2:0] mode;
   logic [VALUE_W-1:0] first_value;
   logic [VALUE_W-1:0] second_value;

   modport source (output valid, output mode, output first_value, output second_value,
                   input ready);
   modport sink (input valid, input mode, input first_value, input second_value,
                 output ready);
endinterface

`default_nettype wire

### src/apg_rsp_if.sv
`default_nettype none

interface apg_rsp_if;
   logic valid;
   logic ready;
   logic alarm_level;
   logic command_ok;

   modport source (output valid, output alarm_level, output command_ok, input ready);
   modport sink (input valid, input alarm_level, input command_ok, output ready);
endinterface

`default_nettype wire

### src/apg_core.sv
`default_nettype none

module apg_core
   import apg_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic fire,
   input wire apg_req_type req,
   output apg_rsp_type rsp
);

   apg_mode_type active_mode_ff, active_mode_in;
   apg_phase_type repeat_phase_ff, repeat_phase_in;
   logic [VALUE_W-1:0] repeat_on_ms_ff, repeat_on_ms_in;
   logic [VALUE_W-1:0] repeat_off_ms_ff, repeat_off_ms_in;
   logic [COUNT_W-1:0] repeat_elapsed_ff, repeat_elapsed_in;
   logic [VALUE_W-1:0] pulse_len_ms_ff, pulse_len_ms_in;
   logic pulse_pending_ff, pulse_pending_in;
   logic [COUNT_W-1:0] pulse_elapsed_ff, pulse_elapsed_in;
   logic [VALUE_W-1:0] toggle_seconds_ff, toggle_seconds_in;
   logic toggle_pending_ff, toggle_pending_in;
   logic [COUNT_W-1:0] toggle_count_ff, toggle_count_in;
   logic [MS_W-1:0] ms_in_second_ff, ms_in_second_in;
   logic output_level_ff, output_level_in;
   logic command_ok;

   logic [MS_W:0] ms_sum;
   logic [MS_W-1:0] ms_next;
   logic [COUNT_W:0] repeat_sum;
   logic [COUNT_W:0] pulse_sum;
   logic [COUNT_W:0] toggle_sum;
   logic [COUNT_W-1:0] repeat_sat;
   logic [COUNT_W-1:0] pulse_sat;
   logic [COUNT_W-1:0] toggle_sat;
   logic first_zero;
   logic second_zero;

   // Uptime within the second; the sum stays below two seconds
   assign ms_sum = {1'b0, ms_in_second_ff} + (MS_W+1)'(MS_PER_TICK);
   assign ms_next = (ms_sum >= (MS_W+1)'(MS_PER_SECOND))
                    ? MS_W'(ms_sum - (MS_W+1)'(MS_PER_SECOND)) : ms_sum[MS_W-1:0];

   // Saturating counter increments
   assign repeat_sum = {1'b0, repeat_elapsed_ff} + (COUNT_W+1)'(MS_PER_TICK);
   assign pulse_sum = {1'b0, pulse_elapsed_ff} + (COUNT_W+1)'(MS_PER_TICK);
   assign toggle_sum = {1'b0, toggle_count_ff} + (COUNT_W+1)'(1);
   assign repeat_sat = repeat_sum[COUNT_W] ? COUNT_MAX : repeat_sum[COUNT_W-1:0];
   assign pulse_sat = pulse_sum[COUNT_W] ? COUNT_MAX : pulse_sum[COUNT_W-1:0];
   assign toggle_sat = toggle_sum[COUNT_W] ? COUNT_MAX : toggle_sum[COUNT_W-1:0];

   assign first_zero = (req.first_value == '0);
   assign second_zero = (req.second_value == '0);

   // Next state for one request
   always_comb begin
      apg_phase_type phase;
      logic [COUNT_W-1:0] elapsed;
      active_mode_in = active_mode_ff;
      repeat_phase_in = repeat_phase_ff;
      repeat_on_ms_in = repeat_on_ms_ff;
      repeat_off_ms_in = repeat_off_ms_ff;
      repeat_elapsed_in = repeat_elapsed_ff;
      pulse_len_ms_in = pulse_len_ms_ff;
      pulse_pending_in = pulse_pending_ff;
      pulse_elapsed_in = pulse_elapsed_ff;
      toggle_seconds_in = toggle_seconds_ff;
      toggle_pending_in = toggle_pending_ff;
      toggle_count_in = toggle_count_ff;
      ms_in_second_in = ms_in_second_ff;
      output_level_in = output_level_ff;
      command_ok = 1'b1;
      phase = repeat_phase_ff;
      elapsed = repeat_elapsed_ff;

      unique case (apg_cmd_type'(req.mode))
         CMD_TICK: begin
            ms_in_second_in = ms_next;
            case (active_mode_ff)
               MODE_OFF: output_level_in = 1'b0;
               MODE_ON: output_level_in = 1'b1;
               MODE_REPEAT: begin
                  // A fresh start enters the on phase, otherwise time runs on
                  if (repeat_phase_ff == PHASE_START) begin
                     elapsed = '0;
                     phase = PHASE_ON;
                     output_level_in = 1'b1;
                  end else begin
                     elapsed = repeat_sat;
                  end
                  if (phase == PHASE_OFF) begin
                     if (elapsed > COUNT_W'(repeat_off_ms_ff)) begin
                        output_level_in = 1'b1;
                        elapsed = '0;
                        phase = PHASE_ON;
                     end
                  end else if (phase == PHASE_ON) begin
                     if (elapsed > COUNT_W'(repeat_on_ms_ff)) begin
                        output_level_in = 1'b0;
                        elapsed = '0;
                        phase = PHASE_OFF;
                     end
                  end
                  repeat_elapsed_in = elapsed;
                  repeat_phase_in = phase;
               end
               MODE_PULSE: begin
                  if (pulse_pending_ff) begin
                     output_level_in = 1'b1;
                     pulse_pending_in = 1'b0;
                     pulse_elapsed_in = '0;
                  end else if (pulse_elapsed_ff > COUNT_W'(pulse_len_ms_ff)) begin
                     output_level_in = 1'b0;
                  end else begin
                     pulse_elapsed_in = pulse_sat;
                  end
               end
               MODE_PULSE2: begin
                  // Start high, then toggle on each whole second of uptime; low once past the limit
                  if (toggle_pending_ff) begin
                     output_level_in = 1'b1;
                     toggle_pending_in = 1'b0;
                     toggle_count_in = '0;
                  end else if (toggle_count_ff > COUNT_W'(toggle_seconds_ff)) begin
                     output_level_in = 1'b0;
                  end else if (ms_next == '0) begin
                     toggle_count_in = toggle_sat;
                     output_level_in = ~output_level_ff;
                  end
               end
               default: ;
            endcase
         end
         CMD_OFF: active_mode_in = MODE_OFF;
         CMD_ON: active_mode_in = MODE_ON;
         CMD_REPEAT: begin
            if (!first_zero && !second_zero) begin
               repeat_on_ms_in = req.first_value;
               repeat_off_ms_in = req.second_value;
               repeat_phase_in = PHASE_START;
               active_mode_in = MODE_REPEAT;
            end else begin
               command_ok = 1'b0;
            end
         end
         CMD_PULSE: begin
            if (!first_zero) begin
               pulse_len_ms_in = req.first_value;
               pulse_pending_in = 1'b1;
               active_mode_in = MODE_PULSE;
            end else begin
               command_ok = 1'b0;
            end
         end
         CMD_PULSE2: begin
            if (!first_zero) begin
               toggle_seconds_in = req.first_value;
               toggle_pending_in = 1'b1;
               active_mode_in = MODE_PULSE2;
            end else begin
               command_ok = 1'b0;
            end
         end
         default: command_ok = 1'b0;
      endcase
   end

   // Result of the request being processed
   always_comb begin
      rsp.alarm_level = output_level_in;
      rsp.command_ok = command_ok;
   end

   // Pattern state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_mode_ff <= MODE_OFF;
         repeat_phase_ff <= PHASE_ON;
         repeat_on_ms_ff <= REPEAT_ON_RESET;
         repeat_off_ms_ff <= REPEAT_OFF_RESET;
         repeat_elapsed_ff <= '0;
         pulse_len_ms_ff <= '0;
         pulse_pending_ff <= 1'b0;
         pulse_elapsed_ff <= '0;
         toggle_seconds_ff <= '0;
         toggle_pending_ff <= 1'b0;
         toggle_count_ff <= '0;
         ms_in_second_ff <= '0;
         output_level_ff <= 1'b0;
      end else if (fire) begin
         active_mode_ff <= active_mode_in;
         repeat_phase_ff <= repeat_phase_in;
         repeat_on_ms_ff <= repeat_on_ms_in;
         repeat_off_ms_ff <= repeat_off_ms_in;
         repeat_elapsed_ff <= repeat_elapsed_in;
         pulse_len_ms_ff <= pulse_len_ms_in;
         pulse_pending_ff <= pulse_pending_in;
         pulse_elapsed_ff <= pulse_elapsed_in;
         toggle_seconds_ff <= toggle_seconds_in;
         toggle_pending_ff <= toggle_pending_in;
         toggle_count_ff <= toggle_count_in;
         ms_in_second_ff <= ms_in_second_in;
         output_level_ff <= output_level_in;
      end
   end

endmodule

`default_nettype wire

### src/alarm_pattern_generator.sv
// Alarm pattern generator.
// Request channel (req): one tick or command per request, taken when valid and
// ready are both high. A tick advances the active pattern by MS_PER_TICK ms;
// commands select off, on, repeat, pulse or pulse2 and take effect on the next
// tick. Start commands with a zero duration are rejected.
// Response channel (rsp): exactly one response per request, carrying the alarm
// level after that request and command_ok.
// Path: a request is captured in the input register, is evaluated against
// the pattern state, and its response is then captured in the result register,
// where it is held until it is taken.
// Throughput: one request per cycle while rsp.ready stays high; the state
// update is a single pass of counter add and compare logic between the input and result registers.
// Reset: synchronous; clears the valid flags of both pipeline registers and
// returns the pattern to off, repeat times 2000/1000 ms, all counters zero.
// Stall: while rsp.ready is low the result register holds and the input
// register fills; then req.ready drops until the response is taken.
`default_nettype none

module alarm_pattern_generator
   import apg_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   apg_req_if.sink req,
   apg_rsp_if.source rsp
);

   logic s1_valid_ff, s1_valid_in;
   apg_req_type s1_req_ff;
   logic s2_valid_ff, s2_valid_in;
   apg_rsp_type s2_rsp_ff;
   apg_rsp_type core_rsp;
   logic advance;
   logic s1_fire;
   logic req_fire;

   // Pipeline flow control
   assign advance = !s2_valid_ff || rsp.ready;
   assign s1_fire = s1_valid_ff && advance;
   assign req.ready = !s1_valid_ff || advance;
   assign req_fire = req.valid && req.ready;

   assign s1_valid_in = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign s2_valid_in = s1_fire ? 1'b1 : (rsp.ready ? 1'b0 : s2_valid_ff);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff.mode <= req.mode;
         s1_req_ff.first_value <= req.first_value;
         s1_req_ff.second_value <= req.second_value;
      end
   end

   // Pattern state and evaluation
   apg_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (s1_fire),
      .req   (s1_req_ff),
      .rsp   (core_rsp)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         s2_rsp_ff <= core_rsp;
      end
   end

   assign rsp.valid = s2_valid_ff;
   assign rsp.alarm_level = s2_rsp_ff.alarm_level;
   assign rsp.command_ok = s2_rsp_ff.command_ok;

endmodule

`default_nettype wire

### tb/testbench.sv
module testbench
   import apg_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Mode codes the block does not define; it must reject them and keep its state
   localparam logic [2:0] CMD_SPARE_A = 3'd6;
   localparam logic [2:0] CMD_SPARE_B = 3'd7;

   localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
   localparam int LONG_HOLD_CYCLES = 120;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PRINT_LIMIT = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;

   apg_req_if req_ch ();
   apg_rsp_if rsp_ch ();

   alarm_pattern_generator dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Traffic shaping
   bit sender_idle = 1'b1;
   bit sink_stalls = 1'b1;
   bit hold_request = 1'b0;

   int errors = 0;
   int quiet_cycles = 0;

   // Predicted alarm state, same reset values as the block
   apg_mode_type alarm_mode = MODE_OFF;
   apg_phase_type repeat_phase = PHASE_ON;
   logic [VALUE_W-1:0] repeat_on_ms = REPEAT_ON_RESET;
   logic [VALUE_W-1:0] repeat_off_ms = REPEAT_OFF_RESET;
   logic [COUNT_W-1:0] repeat_elapsed = '0;
   logic [VALUE_W-1:0] pulse_len_ms = '0;
   logic pulse_pending = 1'b0;
   logic [COUNT_W-1:0] pulse_elapsed = '0;
   logic [VALUE_W-1:0] toggle_seconds = '0;
   logic toggle_pending = 1'b0;
   logic [COUNT_W-1:0] toggle_count = '0;
   logic [MS_W-1:0] ms_in_second = '0;
   logic alarm_level = 1'b0;

   apg_rsp_type pending_alarm_results[$];

   function automatic logic [COUNT_W-1:0] sat_count_add(logic [COUNT_W-1:0] a,
                                                         int unsigned b);
      int unsigned sum;
      sum = a + b;
      return (sum > COUNT_MAX) ? COUNT_MAX : COUNT_W'(sum);
   endfunction

   // Applies one request to the predicted state, returns the response it causes
   function automatic apg_rsp_type next_alarm_result(apg_req_type rq);
      apg_rsp_type result;
      logic ok;
      ok = 1'b1;
      case (rq.mode)
         CMD_TICK: begin
            ms_in_second = MS_W'((ms_in_second + MS_PER_TICK) % MS_PER_SECOND);
            case (alarm_mode)
               MODE_OFF: alarm_level = 1'b0;
               MODE_ON: alarm_level = 1'b1;
               MODE_REPEAT: begin
                  if (repeat_phase == PHASE_START) begin
                     repeat_elapsed = '0;
                     repeat_phase = PHASE_ON;
                     alarm_level = 1'b1;
                  end else begin
                     repeat_elapsed = sat_count_add(repeat_elapsed, MS_PER_TICK);
                  end
                  if (repeat_phase == PHASE_OFF) begin
                     if (repeat_elapsed > repeat_off_ms) begin
                        alarm_level = 1'b1;
                        repeat_elapsed = '0;
                        repeat_phase = PHASE_ON;
                     end
                  end else if (repeat_phase == PHASE_ON) begin
                     if (repeat_elapsed > repeat_on_ms) begin
                        alarm_level = 1'b0;
                        repeat_elapsed = '0;
                        repeat_phase = PHASE_OFF;
                     end
                  end
               end
               MODE_PULSE: begin
                  if (pulse_pending) begin
                     alarm_level = 1'b1;
                     pulse_pending = 1'b0;
                     pulse_elapsed = '0;
                  end else if (pulse_elapsed > pulse_len_ms) begin
                     alarm_level = 1'b0;
                  end else begin
                     pulse_elapsed = sat_count_add(pulse_elapsed, MS_PER_TICK);
                  end
               end
               MODE_PULSE2: begin
                  if (toggle_pending) begin
                     alarm_level = 1'b1;
                     toggle_pending = 1'b0;
                     toggle_count = '0;
                  end else if (toggle_count > toggle_seconds) begin
                     alarm_level = 1'b0;
                  end else if (ms_in_second == '0) begin
                     toggle_count = sat_count_add(toggle_count, 1);
                     alarm_level = ~alarm_level;
                  end
               end
               default: ;
            endcase
         end
         CMD_OFF: alarm_mode = MODE_OFF;
         CMD_ON: alarm_mode = MODE_ON;
         CMD_REPEAT: begin
            if (rq.first_value != '0 && rq.second_value != '0) begin
               repeat_on_ms = rq.first_value;
               repeat_off_ms = rq.second_value;
               repeat_phase = PHASE_START;
               alarm_mode = MODE_REPEAT;
            end else begin
               ok = 1'b0;
            end
         end
         CMD_PULSE: begin
            if (rq.first_value != '0) begin
               pulse_len_ms = rq.first_value;
               pulse_pending = 1'b1;
               alarm_mode = MODE_PULSE;
            end else begin
               ok = 1'b0;
            end
         end
         CMD_PULSE2: begin
            if (rq.first_value != '0) begin
               toggle_seconds = rq.first_value;
               toggle_pending = 1'b1;
               alarm_mode = MODE_PULSE2;
            end else begin
               ok = 1'b0;
            end
         end
         default: ok = 1'b0;
      endcase
      result.alarm_level = alarm_level;
      result.command_ok = ok;
      return result;
   endfunction

   task automatic report_mismatch(string what, int unsigned want, int unsigned got);
      if (errors < PRINT_LIMIT)
         $display("MISMATCH at %0t: %s expected %0d got %0d", $realtime, what, want, got);
      errors++;
   endtask

   // Sends one request; optionally idles first. Returns at the accepting edge.
   task automatic send_request(logic [2:0] mode, logic [VALUE_W-1:0] a,
                               logic [VALUE_W-1:0] b);
      apg_req_type item;
      int gap;
      item.mode = mode;
      item.first_value = a;
      item.second_value = b;
      if (sender_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 19);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode <= item.mode;
      req_ch.first_value <= item.first_value;
      req_ch.second_value <= item.second_value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_alarm_results.push_back(next_alarm_result(item));
   endtask

   // Stops offering and waits until every predicted response has come back
   task automatic wait_for_alarm_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_alarm_results.size() != 0) @(posedge clock);
   endtask

   // A command followed by a run of ticks; some noise and rejected starts mixed in
   task automatic run_random_patterns(int count);
      int sent;
      int kind;
      int ticks;
      logic [2:0] code;
      logic [VALUE_W-1:0] a;
      logic [VALUE_W-1:0] b;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(0, 99);
         a = VALUE_W'($urandom_range(1, 150));
         b = VALUE_W'($urandom_range(1, 150));
         ticks = $urandom_range(1, 40);
         if (kind < 10) begin
            // noise: any code, full-range values, few ticks
            code = 3'($urandom_range(0, 7));
            a = VALUE_W'($urandom);
            b = VALUE_W'($urandom);
            ticks = $urandom_range(0, 3);
         end else if (kind < 16) begin
            code = CMD_OFF;
         end else if (kind < 24) begin
            code = CMD_ON;
         end else if (kind < 50) begin
            code = CMD_REPEAT;
         end else if (kind < 76) begin
            code = CMD_PULSE;
         end else if (kind < 84) begin
            code = CMD_PULSE2;
            a = VALUE_W'($urandom_range(1, 2));
            ticks = $urandom_range(100, 320);
         end else begin
            // broken start with a zero duration
            ticks = $urandom_range(0, 5);
            case ($urandom_range(0, 3))
               0: begin
                  code = CMD_REPEAT;
                  a = '0;
               end
               1: begin
                  code = CMD_REPEAT;
                  b = '0;
               end
               2: begin
                  code = CMD_PULSE;
                  a = '0;
               end
               default: begin
                  code = CMD_PULSE2;
                  a = '0;
               end
            endcase
         end
         send_request(code, a, b);
         sent++;
         repeat (ticks) begin
            send_request(CMD_TICK, VALUE_W'($urandom), VALUE_W'($urandom));
            sent++;
         end
      end
   endtask

   // Field extremes, every code, rejected starts, ignored codes, stale start flags
   task automatic test_directed();
      send_request(CMD_TICK, '0, '0);
      send_request(CMD_ON, VALUE_MAX, VALUE_MAX);
      send_request(CMD_TICK, VALUE_MAX, VALUE_MAX);
      send_request(CMD_OFF, '0, '0);
      send_request(CMD_TICK, '0, '0);
      send_request(CMD_SPARE_A, VALUE_MAX, VALUE_MAX);
      send_request(CMD_SPARE_B, 24'd10, 24'd10);
      send_request(CMD_REPEAT, '0, 24'd5);
      send_request(CMD_REPEAT, 24'd5, '0);
      send_request(CMD_PULSE, '0, VALUE_MAX);
      send_request(CMD_PULSE2, '0, VALUE_MAX);
      send_request(CMD_REPEAT, 24'd10, 24'd10);
      repeat (3) send_request(CMD_TICK, '0, '0);
      send_request(CMD_PULSE, VALUE_MAX, '0);
      send_request(CMD_TICK, '0, '0);
      send_request(CMD_PULSE, 24'd10, '0);
      repeat (2) send_request(CMD_TICK, '0, '0);
      send_request(CMD_PULSE2, VALUE_MAX, VALUE_MAX);
      send_request(CMD_TICK, '0, '0);
      // pending pulse start left behind by a mode change
      send_request(CMD_PULSE, 24'd20, '0);
      send_request(CMD_ON, '0, '0);
      send_request(CMD_REPEAT, VALUE_MAX, VALUE_MAX);
      send_request(CMD_TICK, '0, '0);
   endtask

   task automatic test_random_traffic();
      run_random_patterns(600);
   endtask

   // Receiver holds off long enough that the block fills and stalls its input
   task automatic test_backpressure();
      sender_idle = 1'b0;
      hold_request = 1'b1;
      run_random_patterns(40);
      sender_idle = 1'b1;
   endtask

   // Sender goes quiet until the block has drained
   task automatic test_sender_pause();
      run_random_patterns(20);
      wait_for_alarm_results();
      run_random_patterns(20);
   endtask

   // Closing stretch at full rate on both sides
   task automatic test_full_rate();
      sender_idle = 1'b0;
      sink_stalls = 1'b0;
      run_random_patterns(250);
   endtask

   // Response ready: random stall bursts, one long hold on request
   initial begin : ready_driver
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 19);
            rsp_ch.ready <= 1'b0;
            repeat (stall - 1) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Compare each response with the oldest prediction
   always @(posedge clock) begin : response_checker
      apg_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_alarm_results.size() == 0) begin
            report_mismatch("response with nothing pending, alarm_level",
                            0, rsp_ch.alarm_level);
         end else begin
            want = pending_alarm_results.pop_front();
            if (rsp_ch.alarm_level !== want.alarm_level)
               report_mismatch("alarm_level", want.alarm_level, rsp_ch.alarm_level);
            if (rsp_ch.command_ok !== want.command_ok)
               report_mismatch("command_ok", want.command_ok, rsp_ch.command_ok);
         end
      end
   end

   // Watchdog: too long without any request or response moving
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.mode = CMD_TICK;
      req_ch.first_value = '0;
      req_ch.second_value = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_traffic();
      test_backpressure();
      test_sender_pause();
      test_full_rate();

      wait_for_alarm_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
